### sv/tbc_pkg.sv
// ----------------------------------------------------------------------------
// Threefish-1024 package
// Shared types, constants and permutation/rotation tables.
// ----------------------------------------------------------------------------
package tbc_pkg;

   localparam logic [63:0] KS_CONST = 64'h1BD11BDAA9FC1A22;
   localparam int NUM_WORDS = 16;
   localparam int NUM_KEYS  = 17;

   typedef enum logic [1:0] {
      OP_KEY  = 2'd0,
      OP_ENC  = 2'd1,
      OP_DEC  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef logic [63:0] word_type;
   typedef word_type [NUM_WORDS-1:0] block_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load_block;  // copy gathered words into state
      logic       inject;      // add/subtract subkey
      logic       round;       // apply one round
      logic       decrypt;
      logic [5:0] subkey;      // subkey number, up to 62
      logic [2:0] rnd;         // round index mod 8
      logic       shift_out;   // shift state one word down
   } dp_cmd_type;

   // word index a of pair j in round d (d mod 4)
   function automatic logic [3:0] pair_a(input logic [1:0] d, input int j);
      logic [3:0] t [4][8];
      t = '{'{4'd0,4'd2,4'd4,4'd6,4'd8,4'd10,4'd12,4'd14},
            '{4'd0,4'd2,4'd6,4'd4,4'd10,4'd12,4'd14,4'd8},
            '{4'd0,4'd2,4'd4,4'd6,4'd12,4'd14,4'd8,4'd10},
            '{4'd0,4'd2,4'd6,4'd4,4'd14,4'd8,4'd10,4'd12}};
      return t[d][j];
   endfunction

   function automatic logic [3:0] pair_b(input logic [1:0] d, input int j);
      logic [3:0] t [4][8];
      t = '{'{4'd1,4'd3,4'd5,4'd7,4'd9,4'd11,4'd13,4'd15},
            '{4'd9,4'd13,4'd11,4'd15,4'd7,4'd3,4'd5,4'd1},
            '{4'd7,4'd5,4'd3,4'd1,4'd15,4'd13,4'd11,4'd9},
            '{4'd15,4'd11,4'd13,4'd9,4'd1,4'd5,4'd3,4'd7}};
      return t[d][j];
   endfunction

   function automatic logic [5:0] rot_amt(input logic [2:0] d, input int j);
      logic [5:0] t [8][8];
      t = '{'{6'd24,6'd13,6'd8,6'd47,6'd8,6'd17,6'd22,6'd37},
            '{6'd38,6'd19,6'd10,6'd55,6'd49,6'd18,6'd23,6'd52},
            '{6'd33,6'd4,6'd51,6'd13,6'd34,6'd41,6'd59,6'd17},
            '{6'd5,6'd20,6'd48,6'd41,6'd47,6'd28,6'd16,6'd25},
            '{6'd41,6'd9,6'd37,6'd31,6'd12,6'd47,6'd44,6'd30},
            '{6'd16,6'd34,6'd56,6'd51,6'd4,6'd53,6'd42,6'd41},
            '{6'd31,6'd44,6'd47,6'd46,6'd19,6'd42,6'd44,6'd25},
            '{6'd9,6'd48,6'd35,6'd52,6'd23,6'd31,6'd37,6'd20}};
      return t[d][j];
   endfunction

endpackage

### sv/tbc_datapath.sv
// ----------------------------------------------------------------------------
// Threefish-1024 datapath
// Key schedule, block gathering, round function and subkey injection.
// ----------------------------------------------------------------------------
module tbc_datapath import tbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             key_wr,
   input  logic             data_wr,
   input  logic [63:0]      data_word,
   input  logic             last,
   input  logic [63:0]      tweak_low,
   input  logic [63:0]      tweak_high,
   input  dp_cmd_type       cmd,
   output logic             block_full,
   output logic [63:0]      out_word
);

   word_type    key_ff [NUM_KEYS];
   logic [4:0]  kcnt_ff;
   word_type    buf_ff [NUM_WORDS];
   logic [3:0]  bcnt_ff;
   block_type   x_ff, x_in, x_rnd, x_inj;

   // key schedule upkeep; entry 16 tracks parity at once
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) key_ff[i] <= '0;
         kcnt_ff <= '0;
      end else if (key_wr) begin
         if (kcnt_ff == 5'd0) begin
            for (int i = 0; i < NUM_WORDS; i++) key_ff[i] <= (i == 0) ? data_word : '0;
            key_ff[16] <= KS_CONST ^ data_word;
            kcnt_ff <= last ? 5'd0 : 5'd1;
         end else if (kcnt_ff < 5'd16) begin
            key_ff[kcnt_ff] <= data_word;
            key_ff[16] <= key_ff[16] ^ key_ff[kcnt_ff] ^ data_word;
            kcnt_ff <= last ? 5'd0 : kcnt_ff + 5'd1;
         end else if (last) begin
            kcnt_ff <= '0;
         end
      end
   end

   // block gathering
   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff <= '0;
      end else if (data_wr) begin
         bcnt_ff <= bcnt_ff + 4'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (data_wr) buf_ff[bcnt_ff] <= data_word;
   end
   assign block_full = data_wr && (bcnt_ff == 4'hF);

   // one round, forward or inverse
   always_comb begin
      logic [3:0] a, b;
      logic [5:0] r;
      logic [63:0] s, t;
      x_rnd = x_ff;
      for (int j = 0; j < 8; j++) begin
         a = pair_a(cmd.rnd[1:0], j);
         b = pair_b(cmd.rnd[1:0], j);
         r = rot_amt(cmd.rnd, j);
         if (!cmd.decrypt) begin
            s = x_ff[a] + x_ff[b];
            t = ((x_ff[b] << r) | (x_ff[b] >> (7'd64 - {1'b0, r}))) ^ s;
         end else begin
            t = x_ff[b] ^ x_ff[a];
            t = (t >> r) | (t << (7'd64 - {1'b0, r}));
            s = x_ff[a] - t;
         end
         x_rnd[a] = s;
         x_rnd[b] = t;
      end
   end

   // subkey injection; key index (n+i) mod 17, tweak index n mod 3
   always_comb begin
      logic [4:0] k;
      logic [63:0] v;
      logic [5:0] n17, n3;
      // n is at most 62: reduce by compare and subtract
      n17 = cmd.subkey;
      if (n17 >= 6'd34) n17 = n17 - 6'd34;
      if (n17 >= 6'd17) n17 = n17 - 6'd17;
      n3 = cmd.subkey;
      if (n3 >= 6'd48) n3 = n3 - 6'd48;
      if (n3 >= 6'd24) n3 = n3 - 6'd24;
      if (n3 >= 6'd12) n3 = n3 - 6'd12;
      if (n3 >= 6'd6)  n3 = n3 - 6'd6;
      if (n3 >= 6'd3)  n3 = n3 - 6'd3;
      for (int i = 0; i < NUM_WORDS; i++) begin
         k = n17[4:0] + 5'(i);
         if (k >= 5'd17) k = k - 5'd17;
         v = key_ff[k];
         if (i == 13)
            v = v + ((n3 == 6'd0) ? tweak_low : (n3 == 6'd1) ? tweak_high
                                            : tweak_low ^ tweak_high);
         if (i == 14)
            v = v + ((n3 == 6'd0) ? tweak_high : (n3 == 6'd1) ? (tweak_low ^ tweak_high)
                                            : tweak_low);
         if (i == 15) v = v + 64'(cmd.subkey);
         x_inj[i] = cmd.decrypt ? x_ff[i] - v : x_ff[i] + v;
      end
   end

   // state register
   always_comb begin
      x_in = x_ff;
      if (cmd.load_block) begin
         for (int i = 0; i < 15; i++) x_in[i] = buf_ff[i];
         x_in[15] = data_word;
      end else if (cmd.inject) begin
         x_in = x_inj;
      end else if (cmd.round) begin
         x_in = x_rnd;
      end else if (cmd.shift_out) begin
         x_in = {64'd0, x_ff[15:1]};
      end
   end
   always_ff @(posedge clock) x_ff <= x_in;

   assign out_word = x_ff[0];

endmodule

### sv/tbc_control.sv
// ----------------------------------------------------------------------------
// Threefish-1024 controller
// Sequences rounds, injections and the output burst.
// ----------------------------------------------------------------------------
module tbc_control import tbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        block_full,
   input  logic        block_dec,
   input  logic [4:0]  round_groups,
   output logic        busy,
   output logic        out_valid,
   output logic        out_last,
   output dp_cmd_type  cmd
);

   typedef enum logic [1:0] {S_IDLE, S_INJ, S_RND, S_OUT} state_type;

   state_type  state_ff;
   logic       dec_ff;
   logic [3:0] ocnt_ff;
   // up to 248 rounds
   logic [7:0] total8;
   logic [7:0] stp_ff;   // round counter (encrypt up, decrypt down)
   logic [7:0] tot_ff;

   assign total8 = (round_groups == 5'd0) ? 8'd80 : {round_groups, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stp_ff <= '0;
         tot_ff <= '0;
         dec_ff <= 1'b0;
         ocnt_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (block_full) begin
               dec_ff <= block_dec;
               tot_ff <= total8;
               stp_ff <= block_dec ? total8 : 8'd0;
               state_ff <= S_INJ;
            end
            S_INJ: begin
               if (dec_ff ? (stp_ff == 8'd0) : (stp_ff == tot_ff)) begin
                  state_ff <= S_OUT;
                  ocnt_ff <= '0;
               end else state_ff <= S_RND;
            end
            S_RND: begin
               stp_ff <= dec_ff ? stp_ff - 8'd1 : stp_ff + 8'd1;
               if (dec_ff ? (stp_ff[1:0] == 2'd1) : (stp_ff[1:0] == 2'd3))
                  state_ff <= S_INJ;
            end
            S_OUT: begin
               ocnt_ff <= ocnt_ff + 4'd1;
               if (ocnt_ff == 4'hF) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      logic [7:0] rs;
      rs = dec_ff ? stp_ff - 8'd1 : stp_ff;
      cmd = '0;
      cmd.decrypt    = dec_ff;
      cmd.load_block = (state_ff == S_IDLE) && block_full;
      cmd.inject     = (state_ff == S_INJ);
      cmd.subkey     = stp_ff[7:2];
      cmd.round      = (state_ff == S_RND);
      cmd.rnd        = rs[2:0];
      cmd.shift_out  = (state_ff == S_OUT);
   end

   assign busy      = (state_ff != S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign out_last  = out_valid && (ocnt_ff == 4'hF);

endmodule

### sv/tweakable_block_cipher_1024.sv
// ----------------------------------------------------------------------------
// Threefish-1024 tweakable block cipher
// Once the sixteenth data word is accepted, the block runs its subkey
//   injections and rounds, then gives the result one word a cycle.
// It is busy until the last result word; no key or data items are accepted
//   while busy. One round unit, used once per cycle during rounds. The
//   receiver cannot stall. Sync active-high reset.
// ----------------------------------------------------------------------------
module tweakable_block_cipher_1024 import tbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_data_word,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_word,
   output logic        rsp_last_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [4:0]  groups_ff;
   logic [63:0] tlow_ff, thigh_ff;
   logic        acc, key_wr, data_wr, block_full;
   dp_cmd_type  cmd;

   // config registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         groups_ff <= '0;
         tlow_ff   <= '0;
         thigh_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            2'd0: groups_ff <= csr_data[4:0];
            2'd1: tlow_ff   <= csr_data;
            2'd2: thigh_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign acc     = start && !busy;
   assign key_wr  = acc && (req_operation == OP_KEY);
   assign data_wr = acc && ((req_operation == OP_ENC) || (req_operation == OP_DEC));

   tbc_datapath u_dp (
      .clock, .reset, .key_wr, .data_wr,
      .data_word(req_data_word), .last(req_last),
      .tweak_low(tlow_ff), .tweak_high(thigh_ff),
      .cmd, .block_full, .out_word(rsp_result_word)
   );

   tbc_control u_ctl (
      .clock, .reset, .block_full,
      .block_dec(req_operation == OP_DEC),
      .round_groups(groups_ff),
      .busy, .out_valid(rsp_valid), .out_last(rsp_last_word), .cmd
   );

   // no output outside a run
   a_out_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_last_word |=> !busy) else $error("busy after last word");
   a_full_start: assert property (@(posedge clock) disable iff (reset)
      block_full |=> busy) else $error("block did not start");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threefish-1024 block testbench
// Drives key loads and data words through the command port, programs round
// count and tweak over the register channel, and checks every output word
// against a behavioral cipher model kept inside this bench.
// ----------------------------------------------------------------------------
module tb_top;
   import tbc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] REG_ROUNDS = 2'd0;
   localparam logic [1:0] REG_TWEAK_LO = 2'd1;
   localparam logic [1:0] REG_TWEAK_HI = 2'd2;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [63:0] req_data_word;
   logic        req_last;
   logic        rsp_valid;
   logic [63:0] rsp_result_word;
   logic        rsp_last_word;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   tweakable_block_cipher_1024 dut (.*);

   // bench copy of block state and registers
   logic [4:0]  m_groups;
   logic [63:0] m_tweak_lo, m_tweak_hi;
   logic [63:0] m_sched [17];
   int          m_key_count;
   logic [63:0] m_gather [16];
   int          m_gather_count;

   logic [63:0] exp_word_q [$];
   logic        exp_last_q [$];

   int errors;
   int cycles;
   int words_checked;
   int idle_pct;

   // tables, same as the cipher specification
   int unsigned perm [4][8][2] = '{
      '{'{0,1},'{2,3},'{4,5},'{6,7},'{8,9},'{10,11},'{12,13},'{14,15}},
      '{'{0,9},'{2,13},'{6,11},'{4,15},'{10,7},'{12,3},'{14,5},'{8,1}},
      '{'{0,7},'{2,5},'{4,3},'{6,1},'{12,15},'{14,13},'{8,11},'{10,9}},
      '{'{0,15},'{2,11},'{6,13},'{4,9},'{14,1},'{8,5},'{10,3},'{12,7}}};
   int unsigned rots [8][8] = '{
      '{24,13,8,47,8,17,22,37}, '{38,19,10,55,49,18,23,52},
      '{33,4,51,13,34,41,59,17}, '{5,20,48,41,47,28,16,25},
      '{41,9,37,31,12,47,44,30}, '{16,34,56,51,4,53,42,41},
      '{31,44,47,46,19,42,44,25}, '{9,48,35,52,23,31,37,20}};

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] tweak_sel(int unsigned i);
      if (i == 0) return m_tweak_lo;
      if (i == 1) return m_tweak_hi;
      return m_tweak_lo ^ m_tweak_hi;
   endfunction

   function automatic logic [63:0] rol(logic [63:0] x, int unsigned r);
      if (r == 0) return x;
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic logic [63:0] ror(logic [63:0] x, int unsigned r);
      if (r == 0) return x;
      return (x >> r) | (x << (64 - r));
   endfunction

   task automatic add_subkey(inout logic [63:0] x [16], input int unsigned n,
                             input bit sub);
      logic [63:0] v;
      for (int i = 0; i < 16; i++) begin
         v = m_sched[(n + i) % 17];
         if (i == 13) v += tweak_sel(n % 3);
         if (i == 14) v += tweak_sel((n + 1) % 3);
         if (i == 15) v += 64'(n);
         x[i] = sub ? x[i] - v : x[i] + v;
      end
   endtask

   task automatic cipher_block(inout logic [63:0] x [16], input bit decrypt);
      int unsigned total, d, a, b;
      total = (m_groups == 0) ? 80 : 8 * m_groups;
      if (!decrypt) begin
         add_subkey(x, 0, 1'b0);
         for (int s = 0; s < total; s++) begin
            d = s % 8;
            for (int j = 0; j < 8; j++) begin
               a = perm[d % 4][j][0];
               b = perm[d % 4][j][1];
               x[a] = x[a] + x[b];
               x[b] = rol(x[b], rots[d][j]) ^ x[a];
            end
            if (s % 4 == 3) add_subkey(x, (s + 1) / 4, 1'b0);
         end
      end else begin
         add_subkey(x, total / 4, 1'b1);
         for (int s = total - 1; s >= 0; s--) begin
            d = s % 8;
            for (int j = 0; j < 8; j++) begin
               a = perm[d % 4][j][0];
               b = perm[d % 4][j][1];
               x[b] = ror(x[b] ^ x[a], rots[d][j]);
               x[a] = x[a] - x[b];
            end
            if (s % 4 == 0) add_subkey(x, s / 4, 1'b1);
         end
      end
   endtask

   // update model with one accepted item, queue any output block
   task automatic predict_item(logic [1:0] op, logic [63:0] w, logic lst);
      logic [63:0] x [16];
      if (op == OP_KEY) begin
         if (m_key_count == 0) begin
            for (int i = 0; i < 16; i++) m_sched[i] = '0;
            m_sched[16] = KS_CONST;
         end
         if (m_key_count < 16) begin
            m_sched[16] ^= m_sched[m_key_count] ^ w;
            m_sched[m_key_count] = w;
            m_key_count++;
         end
         if (lst) m_key_count = 0;
      end else if (op != OP_NONE) begin
         m_gather[m_gather_count] = w;
         m_gather_count = (m_gather_count + 1) % 16;
         if (m_gather_count == 0) begin
            x = m_gather;
            cipher_block(x, op == OP_DEC);
            for (int i = 0; i < 16; i++) begin
               exp_word_q.push_back(x[i]);
               exp_last_q.push_back(i == 15);
            end
         end
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %h expected %h (t=%0t)", what, got, want, $realtime);
   endtask

   // output checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (exp_word_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_result_word, '0);
         end else begin
            if (rsp_result_word !== exp_word_q[0])
               report_mismatch("result_word", rsp_result_word, exp_word_q[0]);
            if (rsp_last_word !== exp_last_q[0])
               report_mismatch("last_word", 64'(rsp_last_word), 64'(exp_last_q[0]));
            void'(exp_word_q.pop_front());
            void'(exp_last_q.pop_front());
            words_checked++;
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tweakable_block_cipher_1024 regression: fail");
         $finish;
      end
   end

   // drive at the falling edge; start may drop and rise in the same step
   task automatic send_item(logic [1:0] op, logic [63:0] w, logic lst);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      start = 1'b1;
      req_operation = op;
      req_data_word = w;
      req_last = lst;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_item(op, w, lst);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_drained();
      while (exp_word_q.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ROUNDS:   m_groups = val[4:0];
         REG_TWEAK_LO: m_tweak_lo = val;
         REG_TWEAK_HI: m_tweak_hi = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_block(logic [1:0] op);
      for (int i = 0; i < 16; i++) send_item(op, rand64(), 1'($urandom_range(1)));
   endtask

   task automatic load_key(int unsigned n);
      for (int i = 0; i < n; i++) send_item(OP_KEY, rand64(), i == n - 1);
   endtask

   // directed: zero key, extreme words, short key, mixed ops, ignored op
   task automatic test_directed();
      write_reg(REG_ROUNDS, 64'd1);
      for (int i = 0; i < 16; i++) send_item(OP_ENC, '1, 1'b0);
      send_item(OP_KEY, 64'h0, 1'b0);
      send_item(OP_KEY, '1, 1'b1);
      send_item(OP_NONE, '1, 1'b1);
      for (int i = 0; i < 8; i++) send_item(OP_ENC, '0, 1'b1);
      send_item(OP_KEY, 64'h5555_5555_5555_5555, 1'b1);
      for (int i = 0; i < 7; i++) send_item(OP_DEC, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_item(OP_DEC, 64'h8000_0000_0000_0001, 1'b0);
      wait_drained();
   endtask

   // overlong key, then a block under full rounds
   task automatic test_long_key();
      write_reg(REG_ROUNDS, 64'd0);
      write_reg(REG_TWEAK_LO, '1);
      write_reg(REG_TWEAK_HI, 64'h0123_4567_89AB_CDEF);
      load_key(18);
      send_block(OP_ENC);
      wait_drained();
   endtask

   // random mix under several settings
   task automatic test_random(int unsigned n_blocks);
      int unsigned k;
      for (int b = 0; b < n_blocks; b++) begin
         if (b % 2 == 0) begin
            wait_drained();
            write_reg(REG_ROUNDS, (b % 6 == 0) ? 64'd31 : 64'($urandom_range(4)));
            write_reg(REG_TWEAK_LO, rand64());
            write_reg(REG_TWEAK_HI, rand64());
         end
         k = $urandom_range(9);
         if (k == 0) load_key($urandom_range(1, 17));
         else if (k == 1) send_item(OP_NONE, rand64(), 1'($urandom_range(1)));
         else if (k == 2) send_item(OP_KEY, rand64(), 1'b0);
         send_block($urandom_range(1) ? OP_ENC : OP_DEC);
      end
      wait_drained();
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      words_checked = 0;
      idle_pct = 23;
      m_groups = '0;
      m_tweak_lo = '0;
      m_tweak_hi = '0;
      for (int i = 0; i < 17; i++) m_sched[i] = '0;
      m_key_count = 0;
      m_gather_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_KEY;
      req_data_word = '0;
      req_last = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_ROUNDS;
      csr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_long_key();
      test_random(1);
      idle_pct = 76;
      test_random(1);
      idle_pct = 0;
      test_random(1);

      $display("covered short and overlong key loads, encrypt/decrypt, mixed blocks,");
      $display("8, 80 and 248 rounds with random tweaks; %0d words checked", words_checked);
      if (errors == 0 && exp_word_q.size() == 0) begin
         $display("tweakable_block_cipher_1024 regression: pass");
      end else begin
         $display("tweakable_block_cipher_1024 regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
sv/tbc_pkg.sv
sv/tbc_datapath.sv
sv/tbc_control.sv
sv/tweakable_block_cipher_1024.sv
tb/tb_top.sv
